@@ hdl/assert_macros.svh @@
// Assertion macros used by the top level of the deframer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/mlpd_pkg.sv @@
// Package with the types and constants of the magic and length packet deframer.
`default_nettype none
package mlpd_pkg;
	localparam int COUNT_WIDTH = 31;
	localparam logic [32:0] COUNT_CAP = 33'((64'd1 << COUNT_WIDTH) - 64'd1);
	localparam logic [31:0] MAGIC_RESET = 32'h4270ACE1;
	localparam logic [30:0] MAX_PAYLOAD_RESET = 31'(1024 * 1024 * 1024);
	localparam int ADDR_WIDTH = 3;

	typedef enum logic [0:0] {
		REG_MAGIC_WORD  = 1'b0,
		REG_MAX_PAYLOAD = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_DATA      = 2'd0,
		KIND_EMPTY     = 2'd1,
		KIND_BAD_MAGIC = 2'd2,
		KIND_OVERSIZE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'b001,
		PH_PAYLOAD = 3'b010,
		PH_HALTED  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [31:0] magic_word;
		logic [30:0] max_payload;
	} cfg_t;

	typedef struct packed {
		logic halted;
	} stat_t;
endpackage
`default_nettype wire

@@ hdl/mlpd_if.sv @@
// Stream interfaces for the input bytes and the result items.
`default_nettype none
interface mlpd_in_if;
	logic valid;
	logic ready;
	logic [7:0] data_byte;
	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface mlpd_out_if;
	import mlpd_pkg::*;
	logic valid;
	logic ready;
	kind_t kind;
	logic [7:0] payload_byte;
	logic last;
	modport source (output valid, output kind, output payload_byte, output last, input ready);
	modport sink (input valid, input kind, input payload_byte, input last, output ready);
endinterface
`default_nettype wire

@@ hdl/mlpd_cfg_regs.sv @@
// APB register block holding the expected magic word and the payload limit.
`default_nettype none
module mlpd_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mlpd_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	output mlpd_pkg::cfg_t                      cfg
);
	import mlpd_pkg::*;

	logic [31:0] magic_word_q;
	logic [30:0] max_payload_q;
	reg_idx_t idx;
	logic wr_en;

	assign idx = reg_idx_t'(paddr[2]);
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_word_q <= MAGIC_RESET;
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (wr_en) begin
			case (idx)
				REG_MAGIC_WORD: magic_word_q <= pwdata;
				REG_MAX_PAYLOAD: max_payload_q <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAGIC_WORD: prdata = magic_word_q;
			REG_MAX_PAYLOAD: prdata = {1'b0, max_payload_q};
			default: prdata = '0;
		endcase
	end

	assign cfg.magic_word = magic_word_q;
	assign cfg.max_payload = max_payload_q;
endmodule
`default_nettype wire

@@ hdl/mlpd_parser.sv @@
// Input register, header and payload parser, and result register.
`default_nettype none
module mlpd_parser (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mlpd_pkg::cfg_t cfg,
	mlpd_in_if.sink       rx,
	mlpd_out_if.source    tx,
	output mlpd_pkg::stat_t stat
);
	import mlpd_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic out_valid_q;
	kind_t kind_q;
	logic [7:0] payload_q;
	logic last_q;

	phase_t phase_q;
	phase_t phase_d;
	logic [2:0] hdr_cnt_q;
	logic [2:0] hdr_cnt_d;
	logic [63:0] hdr_shift_q;
	logic [63:0] hdr_shift_d;
	logic [COUNT_WIDTH-1:0] remaining_q;
	logic [COUNT_WIDTH-1:0] remaining_d;
	logic [COUNT_WIDTH-1:0] rem_dec;

	logic adv;
	logic res_valid;
	kind_t res_kind;
	logic [7:0] res_byte;
	logic res_last;
	logic [63:0] assembled;
	logic [32:0] len_ext;

	assign adv = !out_valid_q || tx.ready;
	assign rx.ready = !valid_s1 || adv;
	assign assembled = {hdr_shift_q[55:0], byte_s1};
	assign len_ext = {1'b0, assembled[31:0]};
	assign rem_dec = (remaining_q != '0) ? remaining_q - COUNT_WIDTH'(1) : remaining_q;

	always_comb begin
		phase_d = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		hdr_shift_d = hdr_shift_q;
		remaining_d = remaining_q;
		res_valid = 1'b0;
		res_kind = KIND_DATA;
		res_byte = '0;
		res_last = 1'b0;
		case (phase_q)
			PH_HEADER: begin
				hdr_shift_d = assembled;
				if (hdr_cnt_q != 3'd7) begin
					hdr_cnt_d = hdr_cnt_q + 3'd1;
				end else begin
					hdr_cnt_d = '0;
					if (assembled[63:32] != cfg.magic_word) begin
						phase_d = PH_HALTED;
						res_valid = 1'b1;
						res_kind = KIND_BAD_MAGIC;
					end else if (len_ext > {2'b00, cfg.max_payload} || len_ext > COUNT_CAP) begin
						phase_d = PH_HALTED;
						res_valid = 1'b1;
						res_kind = KIND_OVERSIZE;
					end else if (assembled[31:0] == '0) begin
						res_valid = 1'b1;
						res_kind = KIND_EMPTY;
						res_last = 1'b1;
					end else begin
						remaining_d = assembled[COUNT_WIDTH-1:0];
						phase_d = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				remaining_d = rem_dec;
				res_valid = 1'b1;
				res_kind = KIND_DATA;
				res_byte = byte_s1;
				if (rem_dec == '0) begin
					res_last = 1'b1;
					phase_d = PH_HEADER;
					hdr_cnt_d = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q <= PH_HEADER;
			hdr_cnt_q <= '0;
			hdr_shift_q <= '0;
			remaining_q <= '0;
		end else begin
			if (rx.valid && rx.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= valid_s1 && res_valid;
			end
			if (adv && valid_s1) begin
				phase_q <= phase_d;
				hdr_cnt_q <= hdr_cnt_d;
				hdr_shift_q <= hdr_shift_d;
				remaining_q <= remaining_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data_byte;
		end
		if (adv) begin
			kind_q <= res_kind;
			payload_q <= res_byte;
			last_q <= res_last;
		end
	end

	assign tx.valid = out_valid_q;
	assign tx.kind = kind_q;
	assign tx.payload_byte = payload_q;
	assign tx.last = last_q;
	assign stat.halted = (phase_q == PH_HALTED);
endmodule
`default_nettype wire

@@ hdl/magic_length_packet_deframer.sv @@
// Top level of the magic and length packet deframer.
// The block takes one stream byte per clock while the receiver keeps up. Each byte
// goes into an input register and from there, through the header and payload logic,
// into the result register, which offers the result to the receiver.
// A result that waits on the receiver holds the parser, and the input stalls once the
// input register is full as well.
// A packet starts with an 8-byte big-endian header (magic word, then payload length),
// followed by the payload bytes, which come out one per result with last on the final one.
// A zero-length packet gives one empty-packet result. A wrong magic word or a length
// above the limit gives one error result, after which the block takes and drops every
// byte until reset. Write the registers only while the block is idle.
`default_nettype none
`include "assert_macros.svh"
module magic_length_packet_deframer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	mlpd_in_if.sink                             rx,
	mlpd_out_if.source                          tx,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [mlpd_pkg::ADDR_WIDTH-1:0] paddr,
	input  wire logic [31:0]                    pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import mlpd_pkg::*;

	cfg_t cfg;
	stat_t stat;

	mlpd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mlpd_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.rx     (rx),
		.tx     (tx),
		.stat   (stat)
	);

	`ASSERT_IMPLY(a_err_not_last, clk, arst_n, tx.valid && (tx.kind == KIND_BAD_MAGIC || tx.kind == KIND_OVERSIZE), !tx.last && tx.payload_byte == 8'd0)
	`ASSERT_IMPLY(a_empty_last, clk, arst_n, tx.valid && tx.kind == KIND_EMPTY, tx.last && tx.payload_byte == 8'd0)
	`ASSERT_IMPLY(a_err_halted, clk, arst_n, tx.valid && (tx.kind == KIND_BAD_MAGIC || tx.kind == KIND_OVERSIZE), stat.halted)
	`ASSERT_NEXT(a_halt_sticky, clk, arst_n, stat.halted, stat.halted)
endmodule
`default_nettype wire
